### rtl/joystick_differential_drive_mixer_unit_assert.svh
// ----------------------------------------------------------------------------
// Joystick mixer assertion macros
// Shorthand for clocked properties on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_UNIT_ASSERT_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define JDDM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define JDDM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/jddm_pkg.sv
// ----------------------------------------------------------------------------
// Joystick mixer package
// Shared widths, codes and types for the differential drive mixer.
// ----------------------------------------------------------------------------
package jddm_pkg;

  // Field widths
  localparam int VAL_W     = 12;
  localparam int DUTY_W    = 8;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 3;

  // Divider: dividend covers stick offset times the largest duty limit
  localparam int DVD_W     = 22;
  localparam int DIV_STEPS = DVD_W / 2;
  localparam int STEP_W    = 4;
  localparam logic [STEP_W-1:0] DIV_STEP_LAST = STEP_W'(DIV_STEPS - 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_MOVE    = 2'd0;
  localparam logic [OP_W-1:0] OP_STOP    = 2'd1;
  localparam logic [OP_W-1:0] OP_REVERSE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT    = 3'd4;

  // Configuration reset values
  localparam logic [VAL_W-1:0] MIN_RST      = 12'd1000;
  localparam logic [VAL_W-1:0] MID_RST      = 12'd1500;
  localparam logic [VAL_W-1:0] MAX_RST      = 12'd2000;
  localparam logic [VAL_W-1:0] DEADBAND_RST = 12'd20;

  typedef enum logic [1:0] {
    CMD_DROP,
    CMD_MOVE,
    CMD_REVERSE
  } cmd_kind_t;

  // Classified word handed from front to back
  typedef struct packed {
    cmd_kind_t               kind;
    logic [VAL_W-1:0]        ay;
    logic [VAL_W-1:0]        ax;
    logic                    xright;
    logic                    yfwd;
    logic                    pivot_turn;
    logic                    pivot_mode;
    logic [VAL_W-1:0]        span;
  } cmd_t;

  // One stored drive setting
  typedef struct packed {
    logic [DUTY_W-1:0] ld;
    logic [DUTY_W-1:0] rd;
    logic              ldir;
    logic              rdir;
  } drive_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [VAL_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DVD_W-1:0]  quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SPEED,
    B_TURN,
    B_READ,
    B_DONE
  } back_state_t;

endpackage

### rtl/jddm_front.sv
// ----------------------------------------------------------------------------
// Joystick mixer front end
// Holds the configuration registers, accepts items and classifies them.
// ----------------------------------------------------------------------------
module jddm_front import jddm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      op,
  input  logic [VAL_W-1:0]     stick_y,
  input  logic [VAL_W-1:0]     stick_x,
  input  logic                 q_full,
  output logic                 push,
  output cmd_t                 push_data
);

  logic [VAL_W-1:0] min_value;
  logic [VAL_W-1:0] mid_value;
  logic [VAL_W-1:0] max_value;
  logic [VAL_W-1:0] deadband;
  logic             pivot_mode;

  logic [VAL_W-1:0] y_eff;
  logic [VAL_W-1:0] x_eff;
  logic [VAL_W-1:0] dy;
  logic [VAL_W-1:0] dx;
  logic             y_centred;
  logic             x_centred;
  logic             in_range;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      min_value  <= MIN_RST;
      mid_value  <= MID_RST;
      max_value  <= MAX_RST;
      deadband   <= DEADBAND_RST;
      pivot_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN:      min_value  <= cfg_data;
        REG_MID:      mid_value  <= cfg_data;
        REG_MAX:      max_value  <= cfg_data;
        REG_DEADBAND: deadband   <= cfg_data;
        REG_PIVOT:    pivot_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stop is a move with both sticks at centre
  assign y_eff = (op == OP_STOP) ? mid_value : stick_y;
  assign x_eff = (op == OP_STOP) ? mid_value : stick_x;

  assign in_range = (y_eff >= min_value) && (x_eff >= min_value) &&
                    (y_eff <= max_value) && (x_eff <= max_value);

  // Offsets from centre with deadband
  assign dy = (y_eff >= mid_value) ? (y_eff - mid_value) : (mid_value - y_eff);
  assign dx = (x_eff >= mid_value) ? (x_eff - mid_value) : (mid_value - x_eff);
  assign y_centred = (dy < deadband);
  assign x_centred = (dx < deadband);

  // Classify the word
  always_comb begin
    push_data.ay         = y_centred ? '0 : dy;
    push_data.ax         = x_centred ? '0 : dx;
    push_data.yfwd       = !y_centred && (y_eff > mid_value);
    push_data.xright     = !x_centred && (x_eff > mid_value);
    push_data.pivot_turn = (push_data.ax > deadband);
    push_data.pivot_mode = pivot_mode;
    push_data.span       = (mid_value > min_value) ? (mid_value - min_value) : '0;
    unique case (op)
      OP_MOVE, OP_STOP: push_data.kind = in_range ? CMD_MOVE : CMD_DROP;
      OP_REVERSE:       push_data.kind = CMD_REVERSE;
      default:          push_data.kind = CMD_DROP;
    endcase
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule

### rtl/jddm_queue.sv
// ----------------------------------------------------------------------------
// Joystick mixer command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module jddm_queue import jddm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t       entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rptr];

endmodule

### rtl/jddm_div.sv
// ----------------------------------------------------------------------------
// Joystick mixer divider
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module jddm_div import jddm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step_cnt;
  logic [VAL_W-1:0]  rem;
  logic [DVD_W-1:0]  dvd;
  logic [VAL_W-1:0]  dsr;

  logic [VAL_W:0]    t1;
  logic [VAL_W:0]    t2;
  logic [VAL_W:0]    r1;
  logic [VAL_W:0]    r2;
  logic              ge1;
  logic              ge2;

  // Two compare-subtract steps
  always_comb begin
    t1  = {rem, dvd[DVD_W-1]};
    ge1 = (t1 >= {1'b0, dsr});
    r1  = ge1 ? (t1 - {1'b0, dsr}) : t1;
    t2  = {r1[VAL_W-1:0], dvd[DVD_W-2]};
    ge2 = (t2 >= {1'b0, dsr});
    r2  = ge2 ? (t2 - {1'b0, dsr}) : t2;
  end

  // Iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy     <= 1'b1;
        step_cnt <= '0;
      end else if (busy) begin
        if (step_cnt == DIV_STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step_cnt <= step_cnt + 1'b1;
      end
    end
  end

  // Shift dividend out, quotient in
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-3:0], ge1, ge2};
      rem <= r2[VAL_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

### rtl/jddm_back.sv
// ----------------------------------------------------------------------------
// Joystick mixer back end
// Computes speed and turn, mixes the wheels, keeps the move history ring
// and drives the result register.
// ----------------------------------------------------------------------------
module jddm_back import jddm_pkg::*; #(
  parameter int HISTORY_DEPTH = 16,
  parameter int MAX_DUTY      = 255
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  cmd_t              head,
  output logic              pop,
  output div_req_t          div_req,
  input  div_rsp_t          div_rsp,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              drive_valid,
  output logic [DUTY_W-1:0] left_duty,
  output logic [DUTY_W-1:0] right_duty,
  output logic              left_dir,
  output logic              right_dir,
  output logic              can_reverse
);

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int CAP   = (MAX_DUTY > 255) ? 255 : MAX_DUTY;
  localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(HISTORY_DEPTH);
  localparam logic [DUTY_W-1:0] CAP_V      = DUTY_W'(CAP);
  localparam logic [DVD_W-1:0]  CAP_WIDE   = DVD_W'(CAP);
  localparam logic [DVD_W-1:0]  MAX_DUTY_V = DVD_W'(MAX_DUTY);

  back_state_t             state;
  back_state_t             state_next;
  cmd_t                    cmd;
  logic [DUTY_W-1:0]       speed;
  logic [DUTY_W-1:0]       speed_next;
  logic [DUTY_W-1:0]       slow;
  logic [DUTY_W-1:0]       slow_next;
  logic [PTR_W-1:0]        ptr;
  logic [PTR_W-1:0]        ptr_prev;
  logic [PTR_W-1:0]        ptr_inc;
  logic [CNT_W-1:0]        rev_cnt;
  logic [HISTORY_DEPTH-1:0] hist_vld;
  drive_t                  hist_mem [HISTORY_DEPTH];
  drive_t                  rd_data;
  logic                    rd_vld;

  logic [DUTY_W-1:0]       q_sat;
  logic                    out_free;
  logic                    commit;
  logic                    store;
  logic                    res_valid;
  logic                    res_can_rev;
  drive_t                  res;

  assign ptr_prev = (ptr == '0) ? PTR_LAST : (ptr - 1'b1);
  assign ptr_inc  = (ptr == PTR_LAST) ? '0 : (ptr + 1'b1);
  assign out_free = !out_valid || !out_stall;
  assign q_sat    = (div_rsp.quotient > CAP_WIDE) ? CAP_V : div_rsp.quotient[DUTY_W-1:0];

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, divider requests
  always_comb begin
    state_next       = state;
    pop              = 1'b0;
    commit           = 1'b0;
    speed_next       = speed;
    slow_next        = slow;
    div_req.start    = 1'b0;
    div_req.dividend = DVD_W'(head.ay) * MAX_DUTY_V;
    div_req.divisor  = head.span;
    unique case (state)
      B_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          unique case (head.kind)
            CMD_MOVE: begin
              if (head.span == '0) begin
                speed_next = (head.ay != '0) ? CAP_V : '0;
                slow_next  = (head.ax != '0) ? '0 : speed_next;
                state_next = B_DONE;
              end else begin
                div_req.start = 1'b1;
                state_next    = B_SPEED;
              end
            end
            CMD_REVERSE: state_next = B_READ;
            default:     state_next = B_DONE;
          endcase
        end
      end
      B_SPEED: begin
        div_req.dividend = DVD_W'(cmd.ax) * DVD_W'(q_sat);
        div_req.divisor  = cmd.span;
        if (div_rsp.done) begin
          speed_next    = q_sat;
          div_req.start = 1'b1;
          state_next    = B_TURN;
        end
      end
      B_TURN: begin
        if (div_rsp.done) begin
          slow_next  = (div_rsp.quotient >= DVD_W'(speed)) ? '0 :
                       (speed - div_rsp.quotient[DUTY_W-1:0]);
          state_next = B_DONE;
        end
      end
      B_READ: begin
        state_next = B_DONE;
      end
      B_DONE: begin
        if (out_free) begin
          commit     = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Latch the popped word and the computed speeds
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
    end
    speed <= speed_next;
    slow  <= slow_next;
  end

  // Build the result word
  always_comb begin
    res         = '0;
    res_valid   = 1'b0;
    unique case (cmd.kind)
      CMD_MOVE: begin
        res_valid = 1'b1;
        res.ldir  = !cmd.yfwd;
        res.rdir  = !cmd.yfwd;
        if (cmd.pivot_mode) begin
          res.ld = speed;
          res.rd = speed;
          if (cmd.pivot_turn) begin
            res.ldir = !cmd.xright;
            res.rdir = cmd.xright;
          end
        end else if (cmd.xright) begin
          res.ld = speed;
          res.rd = slow;
        end else begin
          res.ld = slow;
          res.rd = speed;
        end
      end
      CMD_REVERSE: begin
        res_valid = 1'b1;
        if (rd_vld) begin
          res = rd_data;
        end
        res.ldir = !res.ldir;
        res.rdir = !res.rdir;
      end
      default: ;
    endcase
    store       = (cmd.kind == CMD_MOVE) && ((res.ld != '0) || (res.rd != '0));
    res_can_rev = store || (rev_cnt < CNT_FULL);
  end

  // History pointer, reverse count and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      rev_cnt  <= '0;
      hist_vld <= '0;
    end else if (state == B_READ) begin
      ptr <= ptr_prev;
      if (rev_cnt < CNT_FULL) begin
        rev_cnt <= rev_cnt + 1'b1;
      end
    end else if (commit && store) begin
      ptr           <= ptr_inc;
      rev_cnt       <= '0;
      hist_vld[ptr] <= 1'b1;
    end
  end

  // History memory: write on stored move, read on reverse
  always_ff @(posedge clk) begin
    if (commit && store) begin
      hist_mem[ptr] <= res;
    end
    if (state == B_READ) begin
      rd_data <= hist_mem[ptr_prev];
      rd_vld  <= hist_vld[ptr_prev];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      drive_valid <= res_valid;
      left_duty   <= res.ld;
      right_duty  <= res.rd;
      left_dir    <= res.ldir;
      right_dir   <= res.rdir;
      can_reverse <= res_can_rev;
    end
  end

endmodule

### rtl/joystick_differential_drive_mixer_unit.sv
// ----------------------------------------------------------------------------
// Joystick differential drive mixer
// Turns stick words into left/right wheel duties and directions, keeps a
// ring of applied moves and replays it backwards on reverse.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  op, stick_y, stick_x
//   out      out_valid / out_stall drive_valid, left_duty, right_duty,
//                                  left_dir, right_dir, can_reverse
//   cfg      cfg_we               cfg_index, cfg_data
//
// A move passes through pop, two divider passes and the result load; a stop is a
// move at centre. A reverse reads the ring first; a dropped word or a move with
// centre at or below minimum goes straight to the result load. A two-entry queue
// feeds the back end. Reset is synchronous and clears the history ring through its
// valid bits. A result held by out_stall keeps its word; the back end finishes the
// next word meanwhile and waits only to load the result register.
// ----------------------------------------------------------------------------
`include "joystick_differential_drive_mixer_unit_assert.svh"

module joystick_differential_drive_mixer_unit import jddm_pkg::*; #(
  parameter int HISTORY_DEPTH = 16,
  parameter int MAX_DUTY      = 255
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      op,
  input  logic [VAL_W-1:0]     stick_y,
  input  logic [VAL_W-1:0]     stick_x,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 drive_valid,
  output logic [DUTY_W-1:0]    left_duty,
  output logic [DUTY_W-1:0]    right_duty,
  output logic                 left_dir,
  output logic                 right_dir,
  output logic                 can_reverse
);

  localparam int CAP = (MAX_DUTY > 255) ? 255 : MAX_DUTY;
  localparam logic [DUTY_W-1:0] CAP_V = DUTY_W'(CAP);

  logic     q_full;
  logic     push;
  cmd_t     push_data;
  logic     pop;
  logic     q_valid;
  cmd_t     q_head;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Accept and classify
  jddm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .stick_y   (stick_y),
    .stick_x   (stick_x),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Decouple front and back
  jddm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // Shared divider
  jddm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Execute, keep history, drive results
  jddm_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_DUTY      (MAX_DUTY)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_valid),
    .head        (q_head),
    .pop         (pop),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive_valid (drive_valid),
    .left_duty   (left_duty),
    .right_duty  (right_duty),
    .left_dir    (left_dir),
    .right_dir   (right_dir),
    .can_reverse (can_reverse)
  );

  // Dropped words carry an all-zero drive setting
  `JDDM_ASSERT_IMP(a_drop_zero, out_valid && !drive_valid, (left_duty == '0) && (right_duty == '0) && !left_dir && !right_dir, "dropped word with nonzero drive")

  // Duties never exceed the cap
  `JDDM_ASSERT_IMP(a_duty_cap, out_valid, (left_duty <= CAP_V) && (right_duty <= CAP_V), "duty above cap")

  // A word pushed into an empty queue is visible at the head next cycle
  `JDDM_ASSERT_NXT(a_queue_fill, push && !q_valid, q_valid, "pushed word lost in queue")

endmodule

### dv/joystick_differential_drive_mixer_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick mixer checker
// Watches the configuration port and both word channels, keeps its own copy
// of the setup and of the move ring, works out the drive word that each
// accepted stick word must produce and compares every returned word with it.
// ----------------------------------------------------------------------------
module joystick_differential_drive_mixer_unit_checker import jddm_pkg::*; #(
  parameter int HISTORY_DEPTH = 16,
  parameter int MAX_DUTY      = 255
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [OP_W-1:0]      op,
  input  logic [VAL_W-1:0]     stick_y,
  input  logic [VAL_W-1:0]     stick_x,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 drive_valid,
  input  logic [DUTY_W-1:0]    left_duty,
  input  logic [DUTY_W-1:0]    right_duty,
  input  logic                 left_dir,
  input  logic                 right_dir,
  input  logic                 can_reverse,
  output int                   mismatches,
  output int                   pending
);

  localparam int unsigned DUTY_CAP  = (MAX_DUTY > 255) ? 255 : MAX_DUTY;

  // One returned word, laid out in port order
  typedef struct packed {
    logic   drive_valid;
    drive_t drive;
    logic   can_reverse;
  } wheel_word_t;

  // Shadow setup and move ring
  int unsigned min_r, mid_r, max_r, band_r;
  logic        pivot_r;
  drive_t      move_ring [HISTORY_DEPTH];
  int          ring_ptr;
  int          back_steps;

  wheel_word_t drive_expected_q [$];
  int          words_seen;

  function automatic int unsigned offset_of(int unsigned a, int unsigned b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Wheel duties and directions for one in-range stick pair
  function automatic drive_t mix_sticks(int unsigned y, int unsigned x);
    int unsigned sy, sx, ay, ax, span, speed, turn, slow;
    logic        xright;
    drive_t      d;
    sy     = (offset_of(y, mid_r) >= band_r) ? y : mid_r;
    sx     = (offset_of(x, mid_r) >= band_r) ? x : mid_r;
    ay     = offset_of(sy, mid_r);
    ax     = offset_of(sx, mid_r);
    xright = (sx > mid_r);
    span   = (mid_r > min_r) ? mid_r - min_r : 0;
    // centre at or below minimum: all or nothing
    if (span == 0) begin
      speed = (ay != 0) ? DUTY_CAP : 0;
      turn  = (ax != 0) ? speed : 0;
    end else begin
      speed = ay * int'(MAX_DUTY) / span;
      if (speed > DUTY_CAP) speed = DUTY_CAP;
      turn = ax * speed / span;
    end
    d.ldir = (ay != 0 && sy > mid_r) ? 1'b0 : 1'b1;
    d.rdir = d.ldir;
    if (!pivot_r) begin
      // slow the wheel on the turning side, floor at zero
      slow = (turn >= speed) ? 0 : speed - turn;
      d.ld = DUTY_W'(xright ? speed : slow);
      d.rd = DUTY_W'(xright ? slow : speed);
    end else begin
      if (ax > band_r) begin
        d.ldir = ~xright;
        d.rdir = xright;
      end
      d.ld = DUTY_W'(speed);
      d.rd = DUTY_W'(speed);
    end
    return d;
  endfunction

  // Advance the shadow state by one accepted word and queue its result
  task automatic predict_word(logic [OP_W-1:0] code, int unsigned y, int unsigned x);
    wheel_word_t w;
    w = '0;
    if (code == OP_STOP) begin
      y = mid_r;
      x = mid_r;
    end
    if (code == OP_MOVE || code == OP_STOP) begin
      if (y >= min_r && x >= min_r && y <= max_r && x <= max_r) begin
        w.drive       = mix_sticks(y, x);
        w.drive_valid = 1'b1;
        // only moves that turn a wheel enter the ring
        if (w.drive.ld != '0 || w.drive.rd != '0) begin
          move_ring[ring_ptr] = w.drive;
          ring_ptr            = (ring_ptr + 1) % HISTORY_DEPTH;
          back_steps          = 0;
        end
      end
    end else if (code == OP_REVERSE) begin
      ring_ptr = (ring_ptr + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
      if (back_steps < HISTORY_DEPTH) back_steps++;
      w.drive       = move_ring[ring_ptr];
      w.drive.ldir  = ~w.drive.ldir;
      w.drive.rdir  = ~w.drive.rdir;
      w.drive_valid = 1'b1;
    end
    w.can_reverse = (back_steps < HISTORY_DEPTH);
    drive_expected_q.push_back(w);
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] drive word %0d: %s is %0d, expected %0d", $time, words_seen, what, got,
             want);
    mismatches++;
  endtask

  task automatic check_word(wheel_word_t got);
    wheel_word_t want;
    if (drive_expected_q.size() == 0) begin
      report_mismatch("word with nothing pending", 1, 0);
      return;
    end
    want = drive_expected_q.pop_front();
    if (got.drive_valid !== want.drive_valid)
      report_mismatch("drive_valid", got.drive_valid, want.drive_valid);
    if (got.drive.ld !== want.drive.ld) report_mismatch("left_duty", got.drive.ld, want.drive.ld);
    if (got.drive.rd !== want.drive.rd)
      report_mismatch("right_duty", got.drive.rd, want.drive.rd);
    if (got.drive.ldir !== want.drive.ldir)
      report_mismatch("left_dir", got.drive.ldir, want.drive.ldir);
    if (got.drive.rdir !== want.drive.rdir)
      report_mismatch("right_dir", got.drive.rdir, want.drive.rdir);
    if (got.can_reverse !== want.can_reverse)
      report_mismatch("can_reverse", got.can_reverse, want.can_reverse);
  endtask

  // Compare returned words first, then predict the word taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      min_r      = MIN_RST;
      mid_r      = MID_RST;
      max_r      = MAX_RST;
      band_r     = DEADBAND_RST;
      pivot_r    = 1'b0;
      ring_ptr   = 0;
      back_steps = 0;
      words_seen = 0;
      for (int i = 0; i < HISTORY_DEPTH; i++) move_ring[i] = '0;
      drive_expected_q.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_word({drive_valid, left_duty, right_duty, left_dir, right_dir, can_reverse});
        words_seen++;
      end
      if (in_valid && !in_stall) predict_word(op, stick_y, stick_x);
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN:      min_r = cfg_data;
          REG_MID:      mid_r = cfg_data;
          REG_MAX:      max_r = cfg_data;
          REG_DEADBAND: band_r = cfg_data;
          REG_PIVOT:    pivot_r = cfg_data[0];
          default: ;
        endcase
      end
      pending <= drive_expected_q.size();
    end
  end

endmodule

### dv/joystick_differential_drive_mixer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick mixer testbench
// Drives stick words through the mixer under a series of setups (reset
// values, pivot turning, range extremes, centre at or below minimum, heavy
// saturation, random setups) with random idling on both channels and one
// long output hold-off. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module joystick_differential_drive_mixer_unit_test import jddm_pkg::*;;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int          RESET_CYCLES   = 6;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          TAIL_CYCLES    = 60;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int unsigned VAL_TOP        = (1 << VAL_W) - 1;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_MIN;
  logic [VAL_W-1:0]     cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic [OP_W-1:0]      op         = OP_MOVE;
  logic [VAL_W-1:0]     stick_y    = '0;
  logic [VAL_W-1:0]     stick_x    = '0;
  logic                 out_stall  = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 drive_valid;
  logic [DUTY_W-1:0]    left_duty;
  logic [DUTY_W-1:0]    right_duty;
  logic                 left_dir;
  logic                 right_dir;
  logic                 can_reverse;
  int                   mismatches;
  int                   pending;

  // Setup currently programmed, used to aim stick values
  int unsigned cur_min  = MIN_RST;
  int unsigned cur_mid  = MID_RST;
  int unsigned cur_max  = MAX_RST;
  int unsigned cur_band = DEADBAND_RST;

  logic hold_go = 1'b0;
  int   idle_cycles = 0;

  always #10 clk = ~clk;

  joystick_differential_drive_mixer_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .stick_y     (stick_y),
    .stick_x     (stick_x),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive_valid (drive_valid),
    .left_duty   (left_duty),
    .right_duty  (right_duty),
    .left_dir    (left_dir),
    .right_dir   (right_dir),
    .can_reverse (can_reverse)
  );

  joystick_differential_drive_mixer_unit_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .stick_y     (stick_y),
    .stick_x     (stick_x),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive_valid (drive_valid),
    .left_duty   (left_duty),
    .right_duty  (right_duty),
    .left_dir    (left_dir),
    .right_dir   (right_dir),
    .can_reverse (can_reverse),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  // End the run when no word moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: short and long stalls, free-running stretches, one long hold
  initial begin : receiver
    int unsigned pick;
    bit          hold_served;
    hold_served = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_go && !hold_served) begin
        hold_served = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 30)) @(posedge clk);
        end else if (pick < 18) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(15, 60)) @(posedge clk);
        end
      end
    end
  end

  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [VAL_W-1:0] any_val();
    return VAL_W'($urandom_range(0, VAL_TOP));
  endfunction

  // Stick value inside the accepted window, biased to its edges and the deadband
  function automatic logic [VAL_W-1:0] pick_stick();
    int          lo, hi, c;
    int unsigned r;
    lo = cur_min;
    hi = cur_max;
    if (lo > hi) return any_val();
    r = $urandom_range(0, 9);
    case (r)
      0: c = lo;
      1: c = hi;
      2, 3: c = int'(cur_mid) + ($urandom_range(0, 1) ? 1 : -1)
                * (int'(cur_band) + int'($urandom_range(0, 2)) - 1);
      default: c = $urandom_range(lo, hi);
    endcase
    if (c < lo) c = lo;
    if (c > hi) c = hi;
    return VAL_W'(c);
  endfunction

  function automatic bit in_window(int unsigned y, int unsigned x);
    return y >= cur_min && x >= cur_min && y <= cur_max && x <= cur_max;
  endfunction

  // Offer one word, hold it until taken, then idle for a random gap
  task automatic send_word(logic [OP_W-1:0] code, logic [VAL_W-1:0] y, logic [VAL_W-1:0] x,
                           bit steady);
    int unsigned gap;
    gap = steady ? 0 : next_gap();
    in_valid <= 1'b1;
    op       <= code;
    stick_y  <= y;
    stick_x  <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every pending drive word
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setup(int unsigned lo, int unsigned mid, int unsigned hi,
                             int unsigned band, logic pivot);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MIN;
    cfg_data  <= VAL_W'(lo);
    @(posedge clk);
    cfg_index <= REG_MID;
    cfg_data  <= VAL_W'(mid);
    @(posedge clk);
    cfg_index <= REG_MAX;
    cfg_data  <= VAL_W'(hi);
    @(posedge clk);
    cfg_index <= REG_DEADBAND;
    cfg_data  <= VAL_W'(band);
    @(posedge clk);
    // pivot takes bit 0 only; fill the rest with noise
    cfg_index <= REG_PIVOT;
    cfg_data  <= (VAL_W'($urandom_range(0, 2047)) << 1) | VAL_W'(pivot);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_min  = lo;
    cur_mid  = mid;
    cur_max  = hi;
    cur_band = band;
  endtask

  // Mostly in-window moves, with stops, reverse runs, noise and unused codes
  task automatic run_random(int count, bit steady);
    int              counted, tries, run;
    int unsigned     r;
    logic [OP_W-1:0] code;
    logic [VAL_W-1:0] y, x;
    counted = 0;
    tries   = 0;
    while (counted < count && tries < 4 * count) begin
      tries++;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        run = $urandom_range(2, 20);
        repeat (run) send_word(OP_REVERSE, any_val(), any_val(), steady);
        counted += run;
      end else begin
        if (r < 13) code = OP_REVERSE;
        else if (r < 22) code = OP_STOP;
        else if (r < 26) code = OP_UNUSED;
        else code = OP_MOVE;
        if (r >= 26 && r < 36) begin
          y = any_val();
          x = any_val();
        end else begin
          y = pick_stick();
          x = pick_stick();
        end
        send_word(code, y, x, steady);
        if (code == OP_REVERSE || (code == OP_MOVE && in_window(y, x))
            || (code == OP_STOP && in_window(cur_mid, cur_mid)))
          counted++;
      end
    end
  endtask

  task automatic run_phase(int unsigned lo, int unsigned mid, int unsigned hi,
                           int unsigned band, logic pivot, int count);
    settle();
    apply_setup(lo, mid, hi, band, pivot);
    run_random(count, 1'b0);
  endtask

  // Hand-picked words at the reset setup
  task automatic run_directed();
    send_word(OP_REVERSE, 12'd0, 12'd0, 1'b0);        // ring never written
    send_word(OP_MOVE, 12'd2000, 12'd1500, 1'b0);     // full forward
    send_word(OP_MOVE, 12'd1000, 12'd1500, 1'b0);     // full back
    send_word(OP_MOVE, 12'd2000, 12'd2000, 1'b0);     // hard right, inner wheel stops
    send_word(OP_MOVE, 12'd2000, 12'd1000, 1'b0);     // hard left
    send_word(OP_MOVE, 12'd1000, 12'd2000, 1'b0);     // back and right
    send_word(OP_MOVE, 12'd1519, 12'd1481, 1'b0);     // inside deadband, zero duty
    send_word(OP_MOVE, 12'd1520, 12'd1480, 1'b0);     // on the deadband edge
    send_word(OP_MOVE, 12'd1750, 12'd1625, 1'b0);     // partial mix
    send_word(OP_STOP, 12'hFFF, 12'hFFF, 1'b0);
    send_word(OP_MOVE, 12'd999, 12'd1500, 1'b0);      // below minimum
    send_word(OP_MOVE, 12'd1500, 12'd2001, 1'b0);     // above maximum
    send_word(OP_MOVE, 12'd0, 12'd0, 1'b0);
    send_word(OP_MOVE, 12'hFFF, 12'hFFF, 1'b0);
    send_word(OP_UNUSED, 12'd1500, 12'd1700, 1'b0);
    repeat (4) send_word(OP_REVERSE, any_val(), any_val(), 1'b0);
    send_word(OP_MOVE, 12'd1250, 12'd1700, 1'b0);
    send_word(OP_REVERSE, 12'hFFF, 12'h000, 1'b0);
  endtask

  initial begin : stimulus
    int unsigned lo, mid, hi;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    // reset setup again, starting with a reverse run past the ring depth
    settle();
    apply_setup(MIN_RST, MID_RST, MAX_RST, DEADBAND_RST, 1'b0);
    repeat (18) send_word(OP_REVERSE, any_val(), any_val(), 1'b0);
    run_random(100, 1'b0);

    run_phase(1000, 1500, 2000, 20, 1'b1, 90);        // pivot turning
    run_phase(0, VAL_TOP, VAL_TOP, 0, 1'b0, 80);      // widest window, no deadband
    run_phase(0, 2048, VAL_TOP, VAL_TOP, 1'b1, 40);   // deadband swallows everything
    run_phase(0, 0, VAL_TOP, 0, 1'b0, 60);            // centre equal to minimum
    run_phase(2000, 2000, 3000, 10, 1'b1, 60);
    run_phase(3000, 2500, 4000, 7, 1'b0, 60);         // centre below minimum
    run_phase(100, 200, 4000, 5, 1'b0, 90);           // speed and turn saturate
    run_phase(3000, 3500, 2000, 20, 1'b0, 10);        // empty window, all dropped

    // block fills up behind a long output hold
    settle();
    apply_setup(MIN_RST, MID_RST, MAX_RST, DEADBAND_RST, 1'b0);
    hold_go <= 1'b1;
    run_random(60, 1'b1);

    repeat (3) begin
      lo  = $urandom_range(0, 3000);
      mid = lo + $urandom_range(1, 800);
      hi  = mid + $urandom_range(0, 1095);
      if (hi > VAL_TOP) hi = VAL_TOP;
      run_phase(lo, mid, hi, $urandom_range(0, 200), 1'(($urandom_range(0, 1))), 80);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/jddm_pkg.sv
rtl/jddm_front.sv
rtl/jddm_queue.sv
rtl/jddm_div.sv
rtl/jddm_back.sv
rtl/joystick_differential_drive_mixer_unit.sv
dv/joystick_differential_drive_mixer_unit_checker.sv
dv/joystick_differential_drive_mixer_unit_test.sv
